// ----- rtl/rpn_pkg.sv -----
// ============================================================================
// rpn_pkg
// Shared types and codes for the RPN stack calculator: token actions, result
// kinds, error codes and the controller-to-datapath command and status bundles.
// ============================================================================
package rpn_pkg;

    // token actions
    localparam logic [3:0] ACT_PUSH    = 4'd0;
    localparam logic [3:0] ACT_ADD     = 4'd1;
    localparam logic [3:0] ACT_SUB     = 4'd2;
    localparam logic [3:0] ACT_MUL     = 4'd3;
    localparam logic [3:0] ACT_DIV     = 4'd4;
    localparam logic [3:0] ACT_MOD     = 4'd5;
    localparam logic [3:0] ACT_PRINT   = 4'd6;
    localparam logic [3:0] ACT_RECALL  = 4'd7;
    localparam logic [3:0] ACT_ASSIGN  = 4'd8;
    localparam logic [3:0] ACT_LAST    = 4'd9;
    localparam logic [3:0] ACT_PEEK    = 4'd10;
    localparam logic [3:0] ACT_DUP     = 4'd11;
    localparam logic [3:0] ACT_SWAP    = 4'd12;
    localparam logic [3:0] ACT_LIST    = 4'd13;
    localparam logic [3:0] ACT_CLEAR   = 4'd14;

    // result kinds
    localparam logic [2:0] KIND_DONE   = 3'd0;
    localparam logic [2:0] KIND_PRINT  = 3'd1;
    localparam logic [2:0] KIND_TOP    = 3'd2;
    localparam logic [2:0] KIND_HEADER = 3'd3;
    localparam logic [2:0] KIND_ENTRY  = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ZERO_DIV  = 3'd1;
    localparam logic [2:0] ERR_NO_VAR    = 3'd2;
    localparam logic [2:0] ERR_EMPTY     = 3'd3;
    localparam logic [2:0] ERR_TOO_FEW   = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd5;
    localparam logic [2:0] ERR_FULL      = 3'd6;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd7;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_RD_TOP   = 4'd2;
    localparam logic [3:0] OP_POP_B    = 4'd3;
    localparam logic [3:0] OP_POP_A    = 4'd4;
    localparam logic [3:0] OP_PUSH     = 4'd5;
    localparam logic [3:0] OP_ADD      = 4'd6;
    localparam logic [3:0] OP_SUB      = 4'd7;
    localparam logic [3:0] OP_MUL      = 4'd8;
    localparam logic [3:0] OP_MUL_FIN  = 4'd9;
    localparam logic [3:0] OP_DIV_GO   = 4'd10;
    localparam logic [3:0] OP_DIV_FIN  = 4'd11;
    localparam logic [3:0] OP_RD_VAR   = 4'd12;
    localparam logic [3:0] OP_WR_VAR   = 4'd13;
    localparam logic [3:0] OP_SCAN_INC = 4'd14;
    localparam logic [3:0] OP_CLEAR    = 4'd15;

    // value sources for pushes and emitted results
    localparam logic [2:0] SRC_ZERO = 3'd0;
    localparam logic [2:0] SRC_NUM  = 3'd1;
    localparam logic [2:0] SRC_RES  = 3'd2;
    localparam logic [2:0] SRC_VAR  = 3'd3;
    localparam logic [2:0] SRC_LAST = 3'd4;
    localparam logic [2:0] SRC_TOP  = 3'd5;
    localparam logic [2:0] SRC_A    = 3'd6;
    localparam logic [2:0] SRC_B    = 3'd7;

    // iterative divider
    localparam int DIV_W   = 48;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] src;
        logic       emit;
        logic [2:0] kind;
        logic [2:0] err;
        logic       scan_sel;
        logic       finish;
        logic       recall;
    } cmd_t;

    typedef struct packed {
        logic [3:0] action;
        logic       empty;
        logic       single;
        logic       full;
        logic       vidx_ok;
        logic       b_zero;
        logic       var_zero;
        logic       scan_last;
        logic       prev_recall;
        logic       div_busy;
        logic       out_free;
    } stat_t;

endpackage

// ----- rtl/rpn_stack_calculator_unit.sv -----
// ============================================================================
// rpn_stack_calculator_unit
// Reverse Polish calculator over Q16.16 values, one parsed token per transfer.
// ============================================================================
// Usage:
//   s_ channel: one token per transfer (s_action, s_number, s_var_index).
//   m_ channel: one or more results per token; the final result of a token
//   has m_last_of_run set. Tokens are handled one at a time; s_ready is high
//   only while the sequencer is idle, to which it returns as the last result
//   of a token is loaded into the output register.
//   The run time of div and mod is set by the one-bit-per-cycle 48-step
//   divider; list reads the variables one at a time through the single read
//   port of the variable store.
//   Each result sits in a hold register until the next one or the end of the
//   token is known, then moves to the output register; when the receiver
//   stalls, the sequencer waits before producing another result.
//   Reset (aresetn low, synchronous) empties the stack, zeroes all
//   variables and the last printed value, and clears the recall flag.
//   No clearing pass is needed after reset.
// ============================================================================
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_COUNT   = 26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_action,
    input  logic signed [31:0] s_number,
    input  logic [4:0]         s_var_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic signed [31:0] m_value,
    output logic [4:0]         m_var_slot,
    output logic [2:0]         m_error_code,
    output logic               m_last_of_run
);

    rpn_pkg::cmd_t  cmd;
    rpn_pkg::stat_t st;

    // sequencer
    rpn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath
    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_COUNT   (VAR_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_number      (s_number),
        .s_var_index   (s_var_index),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_value       (m_value),
        .m_var_slot    (m_var_slot),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .st            (st)
    );

endmodule

// ----- rtl/rpn_div.sv -----
// ============================================================================
// rpn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module rpn_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rpn_pkg::DIV_W-1:0]  dividend,
    input  logic [31:0]                divisor,
    output logic                       busy,
    output logic [rpn_pkg::DIV_W-1:0]  quotient,
    output logic [31:0]                remainder
);

    logic                            busy_reg;
    logic [rpn_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [rpn_pkg::DIV_W-1:0]       quo_reg;
    logic [31:0]                     rem_reg;
    logic [31:0]                     den_reg;
    logic [32:0]                     trial;
    logic                            ge;
    logic [32:0]                     diff;

    // one shift-subtract step
    always_comb begin
        trial = {rem_reg, quo_reg[rpn_pkg::DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[rpn_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/rpn_ctrl.sv -----
// ============================================================================
// rpn_ctrl
// Token sequencer: walks each token through pops, arithmetic, pushes and
// result emission, issuing one datapath command per cycle unless held by a busy result path or the divider.
// ============================================================================
module rpn_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rpn_pkg::stat_t  st,
    output rpn_pkg::cmd_t   cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_POPB_RD = 5'd2;
    localparam logic [4:0] S_POPB    = 5'd3;
    localparam logic [4:0] S_PRINT   = 5'd4;
    localparam logic [4:0] S_CHKB    = 5'd5;
    localparam logic [4:0] S_ASGCHK  = 5'd6;
    localparam logic [4:0] S_POPA_RD = 5'd7;
    localparam logic [4:0] S_POPA    = 5'd8;
    localparam logic [4:0] S_CALC    = 5'd9;
    localparam logic [4:0] S_MULF    = 5'd10;
    localparam logic [4:0] S_DIVW    = 5'd11;
    localparam logic [4:0] S_PUSHR   = 5'd12;
    localparam logic [4:0] S_SW1     = 5'd13;
    localparam logic [4:0] S_SW2     = 5'd14;
    localparam logic [4:0] S_ASGW    = 5'd15;
    localparam logic [4:0] S_ASGP    = 5'd16;
    localparam logic [4:0] S_RCL     = 5'd17;
    localparam logic [4:0] S_PEEK    = 5'd18;
    localparam logic [4:0] S_DUP     = 5'd19;
    localparam logic [4:0] S_LRD     = 5'd20;
    localparam logic [4:0] S_LCHK    = 5'd21;
    localparam logic [4:0] S_FIN     = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // no transfer is taken while reset is held
    assign s_ready = (state_reg == S_IDLE) && aresetn;

    // next state and command
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && aresetn) begin
                    cmd.op     = rpn_pkg::OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_FIN;
                case (st.action)
                    rpn_pkg::ACT_PUSH, rpn_pkg::ACT_LAST: begin
                        if (st.full) begin
                            cmd.emit = 1'b1;
                            cmd.kind = rpn_pkg::KIND_ERROR;
                            cmd.err  = rpn_pkg::ERR_FULL;
                        end else begin
                            cmd.op  = rpn_pkg::OP_PUSH;
                            cmd.src = (st.action == rpn_pkg::ACT_PUSH) ?
                                      rpn_pkg::SRC_NUM : rpn_pkg::SRC_LAST;
                        end
                    end
                    rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL,
                    rpn_pkg::ACT_DIV, rpn_pkg::ACT_MOD, rpn_pkg::ACT_ASSIGN: begin
                        state_next = S_POPB_RD;
                    end
                    rpn_pkg::ACT_PRINT: begin
                        if (!st.empty) begin
                            state_next = S_POPB_RD;
                        end
                    end
                    rpn_pkg::ACT_RECALL: begin
                        if (st.vidx_ok) begin
                            cmd.op     = rpn_pkg::OP_RD_VAR;
                            state_next = S_RCL;
                        end else begin
                            cmd.emit = 1'b1;
                            cmd.kind = rpn_pkg::KIND_ERROR;
                            cmd.err  = rpn_pkg::ERR_NO_VAR;
                        end
                    end
                    rpn_pkg::ACT_PEEK, rpn_pkg::ACT_DUP: begin
                        if (st.empty) begin
                            cmd.emit = 1'b1;
                            cmd.kind = rpn_pkg::KIND_ERROR;
                            cmd.err  = rpn_pkg::ERR_EMPTY;
                        end else begin
                            cmd.op     = rpn_pkg::OP_RD_TOP;
                            state_next = (st.action == rpn_pkg::ACT_PEEK) ? S_PEEK : S_DUP;
                        end
                    end
                    rpn_pkg::ACT_SWAP: begin
                        if (st.empty || st.single) begin
                            cmd.emit = 1'b1;
                            cmd.kind = rpn_pkg::KIND_ERROR;
                            cmd.err  = rpn_pkg::ERR_TOO_FEW;
                        end else begin
                            state_next = S_POPB_RD;
                        end
                    end
                    rpn_pkg::ACT_LIST: begin
                        cmd.emit     = 1'b1;
                        cmd.kind     = rpn_pkg::KIND_HEADER;
                        cmd.op       = rpn_pkg::OP_RD_VAR;
                        cmd.scan_sel = 1'b1;
                        state_next   = S_LCHK;
                    end
                    rpn_pkg::ACT_CLEAR: begin
                        cmd.op = rpn_pkg::OP_CLEAR;
                    end
                    default: begin
                        cmd.emit = 1'b1;
                        cmd.kind = rpn_pkg::KIND_ERROR;
                        cmd.err  = rpn_pkg::ERR_UNKNOWN;
                    end
                endcase
            end
            // pop right operand
            S_POPB_RD: begin
                cmd.op     = rpn_pkg::OP_RD_TOP;
                state_next = S_POPB;
            end
            S_POPB: begin
                cmd.op   = rpn_pkg::OP_POP_B;
                cmd.emit = st.empty;
                cmd.kind = rpn_pkg::KIND_ERROR;
                cmd.err  = rpn_pkg::ERR_UNDERFLOW;
                case (st.action)
                    rpn_pkg::ACT_DIV, rpn_pkg::ACT_MOD: state_next = S_CHKB;
                    rpn_pkg::ACT_PRINT:                 state_next = S_PRINT;
                    rpn_pkg::ACT_ASSIGN:                state_next = S_ASGCHK;
                    default:                            state_next = S_POPA_RD;
                endcase
            end
            S_PRINT: begin
                cmd.emit   = 1'b1;
                cmd.kind   = rpn_pkg::KIND_PRINT;
                cmd.src    = rpn_pkg::SRC_B;
                state_next = S_FIN;
            end
            S_CHKB: begin
                if (st.b_zero) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = rpn_pkg::KIND_ERROR;
                    cmd.err    = rpn_pkg::ERR_ZERO_DIV;
                    state_next = S_FIN;
                end else begin
                    state_next = S_POPA_RD;
                end
            end
            S_ASGCHK: begin
                if (st.prev_recall) begin
                    state_next = S_POPA_RD;
                end else begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = rpn_pkg::KIND_ERROR;
                    cmd.err    = rpn_pkg::ERR_NO_VAR;
                    state_next = S_FIN;
                end
            end
            // pop left operand
            S_POPA_RD: begin
                cmd.op     = rpn_pkg::OP_RD_TOP;
                state_next = S_POPA;
            end
            S_POPA: begin
                cmd.op     = rpn_pkg::OP_POP_A;
                cmd.emit   = st.empty;
                cmd.kind   = rpn_pkg::KIND_ERROR;
                cmd.err    = rpn_pkg::ERR_UNDERFLOW;
                state_next = S_CALC;
            end
            S_CALC: begin
                case (st.action)
                    rpn_pkg::ACT_ADD: begin
                        cmd.op     = rpn_pkg::OP_ADD;
                        state_next = S_PUSHR;
                    end
                    rpn_pkg::ACT_SUB: begin
                        cmd.op     = rpn_pkg::OP_SUB;
                        state_next = S_PUSHR;
                    end
                    rpn_pkg::ACT_MUL: begin
                        cmd.op     = rpn_pkg::OP_MUL;
                        state_next = S_MULF;
                    end
                    rpn_pkg::ACT_DIV, rpn_pkg::ACT_MOD: begin
                        cmd.op     = rpn_pkg::OP_DIV_GO;
                        state_next = S_DIVW;
                    end
                    rpn_pkg::ACT_SWAP: state_next = S_SW1;
                    default:           state_next = S_ASGW;
                endcase
            end
            S_MULF: begin
                cmd.op     = rpn_pkg::OP_MUL_FIN;
                state_next = S_PUSHR;
            end
            S_DIVW: begin
                if (!st.div_busy) begin
                    cmd.op     = rpn_pkg::OP_DIV_FIN;
                    state_next = S_PUSHR;
                end
            end
            S_PUSHR: begin
                cmd.op     = rpn_pkg::OP_PUSH;
                cmd.src    = rpn_pkg::SRC_RES;
                state_next = S_FIN;
            end
            // swap as pop, pop, push, push
            S_SW1: begin
                cmd.op     = rpn_pkg::OP_PUSH;
                cmd.src    = rpn_pkg::SRC_B;
                state_next = S_SW2;
            end
            S_SW2: begin
                cmd.op     = rpn_pkg::OP_PUSH;
                cmd.src    = rpn_pkg::SRC_A;
                state_next = S_FIN;
            end
            S_ASGW: begin
                cmd.op     = rpn_pkg::OP_WR_VAR;
                state_next = S_ASGP;
            end
            S_ASGP: begin
                cmd.op     = rpn_pkg::OP_PUSH;
                cmd.src    = rpn_pkg::SRC_A;
                state_next = S_FIN;
            end
            S_RCL, S_DUP: begin
                if (st.full) begin
                    cmd.emit = 1'b1;
                    cmd.kind = rpn_pkg::KIND_ERROR;
                    cmd.err  = rpn_pkg::ERR_FULL;
                end else begin
                    cmd.op  = rpn_pkg::OP_PUSH;
                    cmd.src = (state_reg == S_RCL) ? rpn_pkg::SRC_VAR : rpn_pkg::SRC_TOP;
                end
                state_next = S_FIN;
            end
            S_PEEK: begin
                cmd.emit   = 1'b1;
                cmd.kind   = rpn_pkg::KIND_TOP;
                cmd.src    = rpn_pkg::SRC_TOP;
                state_next = S_FIN;
            end
            // variable listing walk
            S_LRD: begin
                cmd.op       = rpn_pkg::OP_RD_VAR;
                cmd.scan_sel = 1'b1;
                state_next   = S_LCHK;
            end
            S_LCHK: begin
                cmd.op     = rpn_pkg::OP_SCAN_INC;
                cmd.emit   = !st.var_zero;
                cmd.kind   = rpn_pkg::KIND_ENTRY;
                cmd.src    = rpn_pkg::SRC_VAR;
                state_next = st.scan_last ? S_FIN : S_LRD;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                cmd.recall = (st.action == rpn_pkg::ACT_RECALL) && st.vidx_ok;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // hold while the result path is busy
        if ((cmd.emit || cmd.finish) && !st.out_free) begin
            cmd        = '0;
            state_next = state_reg;
        end
    end

endmodule

// ----- rtl/rpn_dp.sv -----
// ============================================================================
// rpn_dp
// Datapath: value stack, variable store, operand and result registers,
// multiplier, divider and the result hold/output stage.
// ============================================================================
module rpn_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_COUNT   = 26
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [3:0]           s_action,
    input  logic signed [31:0]   s_number,
    input  logic [4:0]           s_var_index,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [2:0]           m_kind,
    output logic signed [31:0]   m_value,
    output logic [4:0]           m_var_slot,
    output logic [2:0]           m_error_code,
    output logic                 m_last_of_run,
    input  rpn_pkg::cmd_t        cmd,
    output rpn_pkg::stat_t       st
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    // stack and variable storage
    logic signed [31:0] stack_mem [STACK_DEPTH];
    logic signed [31:0] var_mem   [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_vld_reg;

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_m1;
    logic [3:0]         act_reg;
    logic signed [31:0] num_reg;
    logic [4:0]         vidx_reg;
    logic [4:0]         scan_reg;
    logic               prev_recall_reg;
    logic [4:0]         prev_var_reg;
    logic signed [31:0] last_reg;
    logic signed [31:0] top_q;
    logic signed [31:0] var_q;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] res_reg;
    logic signed [63:0] prod_reg;

    logic [4:0]         var_rd_idx;
    logic signed [31:0] sel_val;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [47:0] mul_q;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic [rpn_pkg::DIV_W-1:0] div_dvd;
    logic               div_busy;
    logic [rpn_pkg::DIV_W-1:0] div_quo;
    logic [31:0]        div_rem;
    logic signed [31:0] div_res;

    // result hold and output registers
    logic               hold_v_reg;
    logic [2:0]         hold_kind_reg;
    logic signed [31:0] hold_val_reg;
    logic [4:0]         hold_slot_reg;
    logic [2:0]         hold_err_reg;
    logic               m_valid_reg;
    logic               out_free;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        if (v[47:31] == {17{v[31]}}) begin
            return v[31:0];
        end
        return v[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    assign cnt_m1     = cnt_reg - 1'b1;
    assign var_rd_idx = cmd.scan_sel ? scan_reg : vidx_reg;
    assign out_free   = !m_valid_reg || m_ready;

    // operand and result selection
    always_comb begin
        case (cmd.src)
            rpn_pkg::SRC_NUM:  sel_val = num_reg;
            rpn_pkg::SRC_RES:  sel_val = res_reg;
            rpn_pkg::SRC_VAR:  sel_val = var_q;
            rpn_pkg::SRC_LAST: sel_val = last_reg;
            rpn_pkg::SRC_TOP:  sel_val = top_q;
            rpn_pkg::SRC_A:    sel_val = a_reg;
            rpn_pkg::SRC_B:    sel_val = b_reg;
            default:           sel_val = '0;
        endcase
    end

    // arithmetic
    always_comb begin
        sum   = {a_reg[31], a_reg} + {b_reg[31], b_reg};
        dif   = {a_reg[31], a_reg} - {b_reg[31], b_reg};
        mul_q = prod_reg[63:16] + 48'(prod_reg[63] && (prod_reg[15:0] != '0));
        abs_a = a_reg[31] ? (~a_reg + 1'b1) : a_reg;
        abs_b = b_reg[31] ? (~b_reg + 1'b1) : b_reg;
        div_dvd = (act_reg == rpn_pkg::ACT_DIV) ? {abs_a, 16'h0000} : {16'h0000, abs_a};
        if (act_reg == rpn_pkg::ACT_DIV) begin
            if (a_reg[31] ^ b_reg[31]) begin
                div_res = (div_quo > 48'h0000_8000_0000) ? 32'sh8000_0000 :
                          (~div_quo[31:0] + 1'b1);
            end else begin
                div_res = (div_quo[47:31] != '0) ? 32'sh7fff_ffff : div_quo[31:0];
            end
        end else begin
            div_res = a_reg[31] ? (~div_rem + 1'b1) : div_rem;
        end
    end

    rpn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.op == rpn_pkg::OP_DIV_GO),
        .dividend  (div_dvd),
        .divisor   (abs_b),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // stack memory
    always_ff @(posedge aclk) begin
        if (cmd.op == rpn_pkg::OP_RD_TOP) begin
            top_q <= stack_mem[cnt_m1[AW-1:0]];
        end
        if (cmd.op == rpn_pkg::OP_PUSH) begin
            stack_mem[cnt_reg[AW-1:0]] <= sel_val;
        end
    end

    // variable memory
    always_ff @(posedge aclk) begin
        if (cmd.op == rpn_pkg::OP_RD_VAR) begin
            var_q <= var_vld_reg[var_rd_idx[VW-1:0]] ? var_mem[var_rd_idx[VW-1:0]] : '0;
        end
        if (cmd.op == rpn_pkg::OP_WR_VAR) begin
            var_mem[prev_var_reg[VW-1:0]] <= a_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            var_vld_reg     <= '0;
            prev_recall_reg <= 1'b0;
            prev_var_reg    <= '0;
            last_reg        <= '0;
        end else begin
            case (cmd.op)
                rpn_pkg::OP_POP_A, rpn_pkg::OP_POP_B: begin
                    if (cnt_reg != '0) begin
                        cnt_reg <= cnt_m1;
                    end
                end
                rpn_pkg::OP_PUSH:   cnt_reg <= cnt_reg + 1'b1;
                rpn_pkg::OP_CLEAR:  cnt_reg <= '0;
                rpn_pkg::OP_WR_VAR: var_vld_reg[prev_var_reg[VW-1:0]] <= 1'b1;
                default: ;
            endcase
            if (cmd.emit && cmd.kind == rpn_pkg::KIND_PRINT) begin
                last_reg <= sel_val;
            end
            if (cmd.finish) begin
                prev_recall_reg <= cmd.recall;
                if (cmd.recall) begin
                    prev_var_reg <= vidx_reg;
                end
            end
        end
    end

    // token and operand registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            rpn_pkg::OP_LATCH: begin
                act_reg  <= s_action;
                num_reg  <= s_number;
                vidx_reg <= s_var_index;
                scan_reg <= '0;
            end
            rpn_pkg::OP_POP_B:    b_reg <= (cnt_reg != '0) ? top_q : '0;
            rpn_pkg::OP_POP_A:    a_reg <= (cnt_reg != '0) ? top_q : '0;
            rpn_pkg::OP_ADD: begin
                res_reg <= (sum[32] != sum[31]) ?
                           (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];
            end
            rpn_pkg::OP_SUB: begin
                res_reg <= (dif[32] != dif[31]) ?
                           (dif[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : dif[31:0];
            end
            rpn_pkg::OP_MUL:      prod_reg <= a_reg * b_reg;
            rpn_pkg::OP_MUL_FIN:  res_reg  <= sat48(mul_q);
            rpn_pkg::OP_DIV_FIN:  res_reg  <= div_res;
            rpn_pkg::OP_SCAN_INC: scan_reg <= scan_reg + 1'b1;
            default: ;
        endcase
    end

    // result hold and output stage: the held result is sent once the next
    // one appears or the token finishes, so the final one carries the flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((cmd.emit && hold_v_reg) || cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                hold_v_reg <= 1'b1;
            end else if (cmd.finish) begin
                hold_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            hold_kind_reg <= cmd.kind;
            hold_val_reg  <= (cmd.kind == rpn_pkg::KIND_ERROR ||
                              cmd.kind == rpn_pkg::KIND_HEADER) ? '0 : sel_val;
            hold_slot_reg <= (cmd.kind == rpn_pkg::KIND_ENTRY) ? scan_reg : '0;
            hold_err_reg  <= cmd.err;
            if (hold_v_reg) begin
                m_kind        <= hold_kind_reg;
                m_value       <= hold_val_reg;
                m_var_slot    <= hold_slot_reg;
                m_error_code  <= hold_err_reg;
                m_last_of_run <= 1'b0;
            end
        end else if (cmd.finish) begin
            m_kind        <= hold_v_reg ? hold_kind_reg : rpn_pkg::KIND_DONE;
            m_value       <= hold_v_reg ? hold_val_reg : '0;
            m_var_slot    <= hold_v_reg ? hold_slot_reg : '0;
            m_error_code  <= hold_v_reg ? hold_err_reg : rpn_pkg::ERR_NONE;
            m_last_of_run <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    // status to the controller
    always_comb begin
        st.action      = act_reg;
        st.empty       = (cnt_reg == '0);
        st.single      = (cnt_reg == CW'(1));
        st.full        = (cnt_reg == CW'(STACK_DEPTH));
        st.vidx_ok     = (vidx_reg < 5'(VAR_COUNT));
        st.b_zero      = (b_reg == '0);
        st.var_zero    = (var_q == '0);
        st.scan_last   = (scan_reg == 5'(VAR_COUNT - 1));
        st.prev_recall = prev_recall_reg;
        st.div_busy    = div_busy;
        st.out_free    = out_free;
    end

endmodule
